// File: rtl/scra_pkg.sv
// scra_pkg: shared types, codes, defaults and the size-class function for the
// size-class region allocator. No dependencies; used by scra_cell and the top level.
package scra_pkg;

  // default geometry
  localparam int TableEntriesDef = 16;
  localparam int AddrBitsDef     = 16;

  // fixed field widths
  localparam int START_W  = 16;
  localparam int SIZE_W   = 8;
  localparam int STATUS_W = 2;
  localparam int CLASS_W  = 2;
  localparam int SLOT_W   = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SMALL  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MEDIUM = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LARGE  = 2'd2;

  // register reset values
  localparam logic [SIZE_W-1:0] SMALL_RST  = 8'd10;
  localparam logic [SIZE_W-1:0] MEDIUM_RST = 8'd20;
  localparam logic [SIZE_W-1:0] LARGE_RST  = 8'd50;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_STORED   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OVERLAP  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OVERSIZE = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd3;

  // size class codes
  localparam logic [CLASS_W-1:0] CLS_SMALL  = 2'd0;
  localparam logic [CLASS_W-1:0] CLS_MEDIUM = 2'd1;
  localparam logic [CLASS_W-1:0] CLS_LARGE  = 2'd2;
  localparam logic [CLASS_W-1:0] CLS_NONE   = 2'd3;

  // control flags that travel with the item along the cell row
  typedef struct packed {
    logic valid;
    logic collide;
    logic free_found;
  } scan_flags_t;

  // outcome of the size classification
  typedef struct packed {
    logic               oversize;
    logic [CLASS_W-1:0] cls;
    logic [SIZE_W-1:0]  granted;
  } class_res_t;

  // first class in order small, medium, large that holds the size
  function automatic class_res_t classify(input logic [SIZE_W-1:0] size,
                                          input logic [SIZE_W-1:0] small_sz,
                                          input logic [SIZE_W-1:0] medium_sz,
                                          input logic [SIZE_W-1:0] large_sz);
    class_res_t r;
    r.oversize = 1'b0;
    r.cls      = CLS_NONE;
    r.granted  = '0;
    if (size <= small_sz) begin
      r.cls     = CLS_SMALL;
      r.granted = small_sz;
    end else if (size <= medium_sz) begin
      r.cls     = CLS_MEDIUM;
      r.granted = medium_sz;
    end else if (size <= large_sz) begin
      r.cls     = CLS_LARGE;
      r.granted = large_sz;
    end else begin
      r.oversize = 1'b1;
    end
    return r;
  endfunction

endpackage

// File: rtl/scra_cell.sv
// scra_cell: one table slot of the allocator row. Holds a stored region,
// checks the passing item against it and hands the item to the next cell.
// Depends on scra_pkg.
module scra_cell #(
  parameter int IDX           = 0,
  parameter int TABLE_ENTRIES = scra_pkg::TableEntriesDef,
  parameter int ADDR_BITS     = scra_pkg::AddrBitsDef
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // item from the previous cell
  input  scra_pkg::scan_flags_t             prev_flags,
  input  logic [ADDR_BITS-1:0]              prev_start,
  input  logic [ADDR_BITS:0]                prev_end,
  input  logic [$clog2(TABLE_ENTRIES)-1:0]  prev_free_idx,
  // item to the next cell
  output scra_pkg::scan_flags_t             next_flags,
  output logic [ADDR_BITS-1:0]              next_start,
  output logic [ADDR_BITS:0]                next_end,
  output logic [$clog2(TABLE_ENTRIES)-1:0]  next_free_idx,
  // slot write from the commit step
  input  logic                              wr_en,
  input  logic [$clog2(TABLE_ENTRIES)-1:0]  wr_idx,
  input  logic [ADDR_BITS-1:0]              wr_start,
  input  logic [scra_pkg::SIZE_W-1:0]       wr_len
);

  localparam int IW = $clog2(TABLE_ENTRIES);
  localparam int EW = ADDR_BITS + 1;
  localparam logic [IW-1:0] MY_IDX = IW'(IDX);

  logic                        valid_r;
  logic [ADDR_BITS-1:0]        start_r;
  logic [scra_pkg::SIZE_W-1:0] len_r;

  scra_pkg::scan_flags_t flags_r, flags_nxt;
  logic [ADDR_BITS-1:0]  item_start_r;
  logic [EW-1:0]         item_end_r;
  logic [IW-1:0]         free_idx_r, free_idx_nxt;

  logic [EW-1:0] entry_end;
  logic          hit;

  // overlap test: touching regions collide
  always_comb begin
    entry_end = {1'b0, start_r} + EW'(len_r);
    hit = valid_r && !((entry_end < {1'b0, prev_start}) || (prev_end < {1'b0, start_r}));
  end

  // accumulate collision and lowest free slot
  always_comb begin
    flags_nxt         = prev_flags;
    flags_nxt.collide = prev_flags.collide | hit;
    free_idx_nxt      = prev_free_idx;
    if (!prev_flags.free_found && !valid_r) begin
      flags_nxt.free_found = 1'b1;
      free_idx_nxt         = MY_IDX;
    end
  end

  // slot contents
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (wr_en && (wr_idx == MY_IDX)) begin
      valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && (wr_idx == MY_IDX)) begin
      start_r <= wr_start;
      len_r   <= wr_len;
    end
  end

  // item stage toward the next cell
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r <= '0;
    end else begin
      flags_r <= flags_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_start_r <= prev_start;
    item_end_r   <= prev_end;
    free_idx_r   <= free_idx_nxt;
  end

  assign next_flags    = flags_r;
  assign next_start    = item_start_r;
  assign next_end      = item_end_r;
  assign next_free_idx = free_idx_r;

endmodule

// File: rtl/size_class_region_allocator.sv
// size_class_region_allocator: top level. Classifies each request, runs it
// along a row of scra_cell slots and commits the region. Depends on scra_pkg, scra_cell.
//
// Usage:
//   Input channel in_valid / in_stall carries in_req_start and in_req_size.
//   Result channel out_valid / out_stall carries status, size class, granted
//   size, slack and slot, one result for every item.
//   Config port: cfg_we with cfg_index 0 small, 1 medium, 2 large class size;
//   index 3 is ignored. Write only while the block is idle.
// Sequence:
//   One item at a time. An accepted item is classified into the first cell,
//   passes the registered stage of each slot in turn, is committed into the
//   result register and moves into the output register once that is free; the
//   next item is taken once the block is idle again. Oversize items skip the row.
//   in_stall is low whenever no item is in work, also while a result waits.
// Reset:
//   All slots become free and the class sizes return to 10, 20 and 50.
// Stall:
//   A held result stays in the output register; a finished item waits behind
//   it and the block takes no new item until that one has moved out.
module size_class_region_allocator #(
  parameter int TABLE_ENTRIES = scra_pkg::TableEntriesDef,
  parameter int ADDR_BITS     = scra_pkg::AddrBitsDef
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // request channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [scra_pkg::START_W-1:0]        in_req_start,
  input  logic [scra_pkg::SIZE_W-1:0]         in_req_size,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [scra_pkg::STATUS_W-1:0]       out_status,
  output logic [scra_pkg::CLASS_W-1:0]        out_size_class,
  output logic [scra_pkg::SIZE_W-1:0]         out_granted_size,
  output logic [scra_pkg::SIZE_W-1:0]         out_slack,
  output logic [scra_pkg::SLOT_W-1:0]         out_slot,
  // configuration port
  input  logic                                cfg_we,
  input  logic [scra_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [scra_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int IW = $clog2(TABLE_ENTRIES);
  localparam int EW = ADDR_BITS + 1;

  // sequencer states
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_CLASS = 2'd1;
  localparam logic [1:0] S_SCAN  = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0] state_r, state_nxt;

  // class size registers
  logic [scra_pkg::SIZE_W-1:0] small_r, medium_r, large_r;

  // accepted request
  logic [scra_pkg::START_W-1:0] req_start_r;
  logic [scra_pkg::SIZE_W-1:0]  req_size_r;
  logic [ADDR_BITS-1:0]         req_addr;

  // classification
  scra_pkg::class_res_t        cls_res;
  logic [scra_pkg::CLASS_W-1:0] cls_r;
  logic [scra_pkg::SIZE_W-1:0]  granted_r, slack_r;

  // finished result waiting for the output register
  logic [scra_pkg::STATUS_W-1:0] res_status_r, res_status_nxt;
  logic [scra_pkg::CLASS_W-1:0]  res_class_r, res_class_nxt;
  logic [scra_pkg::SIZE_W-1:0]   res_granted_r, res_granted_nxt;
  logic [scra_pkg::SIZE_W-1:0]   res_slack_r, res_slack_nxt;
  logic [scra_pkg::SLOT_W-1:0]   res_slot_r, res_slot_nxt;

  // output register
  logic                          out_valid_r, out_valid_nxt;
  logic [scra_pkg::STATUS_W-1:0] out_status_r;
  logic [scra_pkg::CLASS_W-1:0]  out_class_r;
  logic [scra_pkg::SIZE_W-1:0]   out_granted_r, out_slack_r;
  logic [scra_pkg::SLOT_W-1:0]   out_slot_r;

  // cell row links
  scra_pkg::scan_flags_t chain_flags [TABLE_ENTRIES+1];
  logic [ADDR_BITS-1:0]  chain_start [TABLE_ENTRIES+1];
  logic [EW-1:0]         chain_end   [TABLE_ENTRIES+1];
  logic [IW-1:0]         chain_idx   [TABLE_ENTRIES+1];

  // commit write
  logic          wr_en;
  logic [IW-1:0] wr_idx;
  logic          in_fire, out_fire, load_out;
  scra_pkg::scan_flags_t last_flags;

  assign in_fire  = in_valid && !in_stall;
  assign out_fire = out_valid_r && !out_stall;
  assign load_out = (state_r == S_DONE) && (!out_valid_r || !out_stall);
  assign in_stall = (state_r != S_IDLE);
  assign req_addr = ADDR_BITS'(req_start_r);
  assign cls_res  = scra_pkg::classify(req_size_r, small_r, medium_r, large_r);
  assign last_flags = chain_flags[TABLE_ENTRIES];

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      small_r  <= scra_pkg::SMALL_RST;
      medium_r <= scra_pkg::MEDIUM_RST;
      large_r  <= scra_pkg::LARGE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        scra_pkg::REG_SMALL:  small_r  <= cfg_data;
        scra_pkg::REG_MEDIUM: medium_r <= cfg_data;
        scra_pkg::REG_LARGE:  large_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_start_r <= in_req_start;
      req_size_r  <= in_req_size;
    end
  end

  // class registers for the commit step
  always_ff @(posedge clk) begin
    if (state_r == S_CLASS) begin
      cls_r     <= cls_res.cls;
      granted_r <= cls_res.granted;
      slack_r   <= cls_res.granted - req_size_r;
    end
  end

  // item enters the first cell
  always_comb begin
    chain_flags[0]            = '0;
    chain_flags[0].valid      = (state_r == S_CLASS) && !cls_res.oversize;
    chain_start[0]            = req_addr;
    chain_end[0]              = {1'b0, req_addr} + EW'(cls_res.granted);
    chain_idx[0]              = '0;
  end

  // row of table cells
  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
    scra_cell #(
      .IDX          (g),
      .TABLE_ENTRIES(TABLE_ENTRIES),
      .ADDR_BITS    (ADDR_BITS)
    ) u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .prev_flags   (chain_flags[g]),
      .prev_start   (chain_start[g]),
      .prev_end     (chain_end[g]),
      .prev_free_idx(chain_idx[g]),
      .next_flags   (chain_flags[g+1]),
      .next_start   (chain_start[g+1]),
      .next_end     (chain_end[g+1]),
      .next_free_idx(chain_idx[g+1]),
      .wr_en        (wr_en),
      .wr_idx       (wr_idx),
      .wr_start     (chain_start[TABLE_ENTRIES]),
      .wr_len       (granted_r)
    );
  end

  // commit decision when the item leaves the row; oversize items are settled at classification
  always_comb begin
    wr_en  = 1'b0;
    wr_idx = chain_idx[TABLE_ENTRIES];
    res_status_nxt  = res_status_r;
    res_class_nxt   = res_class_r;
    res_granted_nxt = res_granted_r;
    res_slack_nxt   = res_slack_r;
    res_slot_nxt    = res_slot_r;
    if ((state_r == S_CLASS) && cls_res.oversize) begin
      res_status_nxt  = scra_pkg::ST_OVERSIZE;
      res_class_nxt   = scra_pkg::CLS_NONE;
      res_granted_nxt = '0;
      res_slack_nxt   = '0;
      res_slot_nxt    = '0;
    end else if ((state_r == S_SCAN) && last_flags.valid) begin
      res_class_nxt   = cls_r;
      res_granted_nxt = granted_r;
      res_slack_nxt   = slack_r;
      res_slot_nxt    = '0;
      if (last_flags.collide) begin
        res_status_nxt = scra_pkg::ST_OVERLAP;
      end else if (!last_flags.free_found) begin
        res_status_nxt = scra_pkg::ST_FULL;
      end else begin
        res_status_nxt = scra_pkg::ST_STORED;
        res_slot_nxt   = scra_pkg::SLOT_W'(chain_idx[TABLE_ENTRIES]);
        wr_en          = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    res_status_r  <= res_status_nxt;
    res_class_r   <= res_class_nxt;
    res_granted_r <= res_granted_nxt;
    res_slack_r   <= res_slack_nxt;
    res_slot_r    <= res_slot_nxt;
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_fire) state_nxt = S_CLASS;
      S_CLASS: state_nxt = cls_res.oversize ? S_DONE : S_SCAN;
      S_SCAN:  if (last_flags.valid) state_nxt = S_DONE;
      S_DONE:  if (load_out) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_fire) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_status_r  <= res_status_r;
      out_class_r   <= res_class_r;
      out_granted_r <= res_granted_r;
      out_slack_r   <= res_slack_r;
      out_slot_r    <= res_slot_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_size_class   = out_class_r;
  assign out_granted_size = out_granted_r;
  assign out_slack        = out_slack_r;
  assign out_slot         = out_slot_r;

endmodule
